// ===== hw/rtl/tsms_pkg.sv =====
// Package with shared types, constants and codes of the stroke motion sequencer.
`default_nettype none
package tsms_pkg;
	localparam int AlphaFracBitsDef = 16;
	localparam int ElapsedW = 17;

	typedef enum logic [2:0] {
		REQ_TICK = 3'd0, REQ_STARTUP = 3'd1, REQ_PUSH = 3'd2,
		REQ_UP = 3'd3, REQ_DOWN = 3'd4, REQ_OFF = 3'd5
	} req_t;

	typedef enum logic [2:0] {
		PH_OFF = 3'd0, PH_UP = 3'd1, PH_DOWN = 3'd2, PH_STARTUP = 3'd3, PH_PUSH = 3'd4
	} phase_t;

	typedef enum logic [2:0] {
		SEQ_IDLE, SEQ_DIV, SEQ_MUL1, SEQ_MUL2, SEQ_MUL3, SEQ_DONE
	} seq_state_t;

	localparam logic [2:0] REG_STROKE = 3'd0;
	localparam logic [2:0] REG_UPDUR = 3'd1;
	localparam logic [2:0] REG_DNDUR = 3'd2;
	localparam logic [2:0] REG_DNTGT = 3'd3;
	localparam logic [2:0] REG_STARTUP = 3'd4;
	localparam logic [2:0] REG_PRESS = 3'd5;

	// Request from the sequencer to the arithmetic unit.
	typedef struct packed {
		logic                start;
		logic [ElapsedW-1:0] elapsed;
		logic [15:0]         duration;
		logic signed [15:0]  from_pos;
		logic signed [15:0]  to_pos;
	} calc_req_t;
endpackage
`default_nettype wire

// ===== hw/rtl/timed_stroke_motion_sequencer_top.sv =====
// Top level of the timed stroke motion sequencer.
// A request is either a 1 ms tick or a phase command; each request yields exactly one
// result. Commands and ticks outside the up and down phases skip the smoothstep unit
// and put their result in the output register once the output is free. A tick in the
// up or down phase runs the bit-serial smoothstep unit, a restoring divide and then
// three shift-add multiplies; its result goes to the output register once the unit is
// done and the output is free, and a new request is taken only after that. One
// request is in work at a time; a finished result waits in the output register while
// the next request is taken, and a stalled output holds the following result back.
`default_nettype none
module timed_stroke_motion_sequencer_top #(
	parameter int ALPHA_FRAC_BITS = tsms_pkg::AlphaFracBitsDef
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [4:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic [31:0]      prdata,
	output logic             pready,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [2:0]  req_type,
	input  wire logic signed [15:0] motor_position,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic [2:0]       phase,
	output logic             control_mode,
	output logic [1:0]       gain_set,
	output logic signed [15:0] target_position,
	output logic             target_valid,
	output logic             zero_pulse,
	output logic             motor_off
);
	import tsms_pkg::*;

	logic [15:0] stroke_q, updur_q, dndur_q, dntgt_q, sutime_q, press_q;
	phase_t phase_q;
	logic [ElapsedW-1:0] elapsed_q;
	logic signed [15:0] start_q;
	logic busy_q, wait_q, cready_q;
	logic [ElapsedW-1:0] el_inc;
	logic [2:0] reg_idx;
	calc_req_t creq;
	logic cdone;
	logic signed [15:0] ctarget;
	phase_t next_ph_q;
	logic res_zero_q;
	logic in_acc, out_free, fin;
	phase_t nxt_ph;
	logic [ElapsedW-1:0] nxt_el;
	logic signed [15:0] nxt_start;
	logic nxt_zero;

	assign reg_idx = paddr[4:2];
	assign pready = 1'b1;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stroke_q <= 16'd0; updur_q <= 16'd750; dndur_q <= 16'd750;
			dntgt_q <= 16'd50; sutime_q <= 16'd1000; press_q <= 16'd250;
		end else if (psel && penable && pwrite) begin
			case (reg_idx)
				REG_STROKE:  stroke_q <= pwdata[15:0];
				REG_UPDUR:   updur_q  <= pwdata[15:0];
				REG_DNDUR:   dndur_q  <= pwdata[15:0];
				REG_DNTGT:   dntgt_q  <= pwdata[15:0];
				REG_STARTUP: sutime_q <= pwdata[15:0];
				REG_PRESS:   press_q  <= pwdata[15:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			REG_STROKE:  prdata = {16'd0, stroke_q};
			REG_UPDUR:   prdata = {16'd0, updur_q};
			REG_DNDUR:   prdata = {16'd0, dndur_q};
			REG_DNTGT:   prdata = {16'd0, dntgt_q};
			REG_STARTUP: prdata = {16'd0, sutime_q};
			REG_PRESS:   prdata = {16'd0, press_q};
			default:     prdata = 32'd0;
		endcase
	end

	assign in_stall = busy_q;
	assign in_acc   = in_valid && !busy_q;
	assign out_free = !out_valid || !out_stall;
	assign fin      = busy_q && (!wait_q || cready_q) && out_free;
	assign el_inc   = (elapsed_q == '1) ? elapsed_q : elapsed_q + 1'b1;

	// Smoothstep request for a tick in the up or down phase.
	always_comb begin
		creq.start    = in_acc && req_type == REQ_TICK &&
			(phase_q == PH_UP || phase_q == PH_DOWN);
		creq.elapsed  = el_inc;
		creq.duration = (phase_q == PH_UP) ? updur_q : dndur_q;
		creq.from_pos = start_q;
		creq.to_pos   = (phase_q == PH_UP) ? stroke_q : dntgt_q;
	end

	tsms_calc #(.ALPHA_FRAC_BITS(ALPHA_FRAC_BITS)) u_calc (
		.clk(clk), .arst_n(arst_n), .req(creq), .done(cdone), .target(ctarget)
	);

	// Next phase, elapsed time and start position for the request on the input.
	always_comb begin
		nxt_ph = phase_q;
		nxt_el = elapsed_q;
		nxt_start = start_q;
		nxt_zero = 1'b0;
		case (req_type)
			REQ_TICK: begin
				if (phase_q != PH_OFF) begin
					nxt_el = el_inc;
					case (phase_q)
						PH_STARTUP: if (el_inc > ElapsedW'(sutime_q)) begin
							nxt_zero = 1'b1; nxt_ph = PH_OFF;
						end
						PH_PUSH: if (el_inc > ElapsedW'(press_q)) begin
							nxt_zero = 1'b1; nxt_ph = PH_UP;
							nxt_el = '0; nxt_start = '0;
						end
						PH_UP: if (el_inc > ElapsedW'(updur_q)) nxt_ph = PH_OFF;
						PH_DOWN: if (el_inc > ElapsedW'(dndur_q)) begin
							nxt_ph = PH_PUSH; nxt_el = '0;
							nxt_start = motor_position;
						end
						default: nxt_ph = PH_OFF;
					endcase
				end
			end
			REQ_STARTUP: begin nxt_ph = PH_STARTUP; nxt_el = '0; nxt_start = '0; end
			REQ_PUSH: begin nxt_ph = PH_PUSH; nxt_el = '0; nxt_start = motor_position; end
			REQ_UP: begin nxt_ph = PH_UP; nxt_el = '0; nxt_start = motor_position; end
			REQ_DOWN: begin nxt_ph = PH_DOWN; nxt_el = '0; nxt_start = motor_position; end
			REQ_OFF: nxt_ph = PH_OFF;
			default: ;
		endcase
	end

	// Phase sequencing and result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_OFF; elapsed_q <= '0; start_q <= '0;
			busy_q <= 1'b0; wait_q <= 1'b0; cready_q <= 1'b0; out_valid <= 1'b0;
			phase <= '0; control_mode <= 1'b0; gain_set <= '0;
			target_position <= '0; target_valid <= 1'b0; zero_pulse <= 1'b0;
			motor_off <= 1'b1; next_ph_q <= PH_OFF; res_zero_q <= 1'b0;
		end else begin
			if (out_valid && !out_stall && !fin) out_valid <= 1'b0;
			if (in_acc) begin
				busy_q <= 1'b1;
				wait_q <= creq.start;
				cready_q <= 1'b0;
				next_ph_q <= nxt_ph;
				elapsed_q <= nxt_el;
				start_q <= nxt_start;
				res_zero_q <= nxt_zero;
			end else if (fin) begin
				busy_q <= 1'b0; wait_q <= 1'b0; cready_q <= 1'b0; out_valid <= 1'b1;
				phase_q <= next_ph_q;
				phase <= next_ph_q;
				control_mode <= (next_ph_q == PH_UP || next_ph_q == PH_DOWN);
				gain_set <= (next_ph_q == PH_UP) ? 2'd1 : (next_ph_q == PH_DOWN) ? 2'd2 : 2'd0;
				target_position <= wait_q ? ctarget : 16'sd0;
				target_valid <= wait_q;
				zero_pulse <= res_zero_q;
				motor_off <= (next_ph_q == PH_OFF);
			end else if (busy_q && wait_q && cdone) begin
				// The smoothstep target stays in the unit until the output is free.
				cready_q <= 1'b1;
			end
		end
	end
endmodule
`default_nettype wire

// ===== hw/rtl/tsms_calc.sv =====
// Bit-serial smoothstep unit: restoring divide, then three shift-add multiplies.
`default_nettype none
module tsms_calc #(
	parameter int ALPHA_FRAC_BITS = tsms_pkg::AlphaFracBitsDef
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire tsms_pkg::calc_req_t req,
	output logic                     done,
	output logic signed [15:0]       target
);
	import tsms_pkg::*;

	localparam int F = ALPHA_FRAC_BITS;
	localparam int AW = F + 1;              // alpha holds up to 2^F
	localparam int NW = ElapsedW + F;       // dividend width
	localparam int SW = F + 2;              // 3*2^F - 2*alpha width
	localparam int DW = 17;                 // delta width
	localparam int PW = AW + DW;            // final product width
	localparam int CW = $clog2(NW + 1);
	localparam logic [AW-1:0] ONE = AW'(1) << F;

	seq_state_t state_q, state_d;
	logic [CW-1:0] cnt_q;
	logic [NW-1:0] num_q;          // dividend shifting out, quotient shifting in
	logic [16:0]   rem_q;
	logic [15:0]   dur_q;
	logic [2*AW-1:0] acc_q;
	logic [2*AW-1:0] mcand_q;
	logic [SW-1:0]   mplr_q;
	logic [AW-1:0]   alpha_q;
	logic signed [15:0] from_q;
	logic signed [DW-1:0] delta_q;
	logic signed [PW:0] prod_q;
	logic signed [15:0] target_q;

	logic [17:0] rem_sh;
	logic [17:0] rem_try;
	logic [NW-1:0] quo;
	logic [AW-1:0] alpha_c;
	logic signed [PW:0] pos_w;

	// One quotient bit per cycle.
	assign rem_sh  = {rem_q, num_q[NW-1]};
	assign rem_try = rem_sh - {2'b0, dur_q};
	assign quo     = num_q;
	assign alpha_c = (dur_q == '0 || quo > NW'(ONE)) ? ONE : quo[AW-1:0];

	// Quotient of the signed product by 2^F truncates toward zero.
	always_comb begin
		pos_w = (prod_q + ((prod_q < 0) ? (PW+1)'((1 << F) - 1) : (PW+1)'(0))) >>> F;
		pos_w = pos_w + (PW+1)'(from_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= SEQ_IDLE;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			if (state_q != state_d) cnt_q <= '0;
			else cnt_q <= cnt_q + 1'b1;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			SEQ_IDLE: if (req.start) state_d = SEQ_DIV;
			SEQ_DIV:  if (cnt_q == CW'(NW - 1)) state_d = SEQ_MUL1;
			SEQ_MUL1: if (cnt_q == CW'(AW)) state_d = SEQ_MUL2;
			SEQ_MUL2: if (cnt_q == CW'(SW - 1)) state_d = SEQ_MUL3;
			SEQ_MUL3: if (cnt_q == CW'(DW - 1)) state_d = SEQ_DONE;
			SEQ_DONE: state_d = SEQ_IDLE;
			default:  state_d = SEQ_IDLE;
		endcase
	end

	// Datapath: the divide and multiply phases each take one bit of a quotient or multiplier per cycle.
	always_ff @(posedge clk) begin
		case (state_q)
			SEQ_IDLE: begin
				num_q   <= NW'(req.elapsed) << F;
				rem_q   <= '0;
				dur_q   <= req.duration;
				from_q  <= req.from_pos;
				delta_q <= DW'(req.to_pos) - DW'(req.from_pos);
			end
			SEQ_DIV: begin
				if (!rem_try[17]) begin
					rem_q <= rem_try[16:0];
					num_q <= {num_q[NW-2:0], 1'b1};
				end else begin
					rem_q <= rem_sh[16:0];
					num_q <= {num_q[NW-2:0], 1'b0};
				end
				if (cnt_q == CW'(NW - 1)) begin
					// MUL1 follows, which loads alpha and multiplies it by itself.
					acc_q <= '0;
				end
			end
			SEQ_MUL1: begin
				// Load alpha, then one multiplier bit per cycle, the top bit on the last.
				if (cnt_q == '0) begin
					alpha_q <= alpha_c;
					mcand_q <= (2*AW)'(alpha_c);
					mplr_q  <= SW'(alpha_c);
					acc_q   <= '0;
				end else if (cnt_q == CW'(AW)) begin
					mplr_q  <= (SW'(3) << F) - (SW'(alpha_q) << 1);
					mcand_q <= (2*AW)'(((mplr_q[0] ? acc_q + mcand_q : acc_q)) >> F);
					acc_q   <= '0;
				end else begin
					if (mplr_q[0]) acc_q <= acc_q + mcand_q;
					mcand_q <= mcand_q << 1;
					mplr_q  <= mplr_q >> 1;
				end
			end
			SEQ_MUL2: begin
				if (cnt_q == CW'(SW - 1)) begin
					mcand_q <= (2*AW)'(((mplr_q[0] ? acc_q + mcand_q : acc_q)) >> F);
					prod_q  <= '0;
				end else begin
					if (mplr_q[0]) acc_q <= acc_q + mcand_q;
					mcand_q <= mcand_q << 1;
					mplr_q  <= mplr_q >> 1;
				end
			end
			SEQ_MUL3: begin
				// Signed multiply, two's complement on the top delta bit.
				if (cnt_q == CW'(DW - 1)) begin
					if (delta_q[cnt_q[$clog2(DW)-1:0]])
						prod_q <= prod_q - ((PW+1)'(mcand_q[AW-1:0]) << (DW - 1));
				end else if (delta_q[cnt_q[$clog2(DW)-1:0]]) begin
					prod_q <= prod_q + ((PW+1)'(mcand_q[AW-1:0]) << cnt_q);
				end
			end
			SEQ_DONE: begin
				if (pos_w > 32767) target_q <= 16'sd32767;
				else if (pos_w < -32768) target_q <= -16'sd32768;
				else target_q <= pos_w[15:0];
			end
			default: ;
		endcase
	end

	assign done   = (state_q == SEQ_DONE);
	assign target = target_q;
endmodule
`default_nettype wire

// ===== hw/rtl/tsms_checker.sv =====
// Port-level checker for the stroke motion sequencer, bound to the top level.
`default_nettype none
module tsms_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        in_valid,
	input wire logic        in_stall,
	input wire logic        out_valid,
	input wire logic        out_stall,
	input wire logic [2:0]  phase,
	input wire logic        control_mode,
	input wire logic        target_valid,
	input wire logic        motor_off
);
	import tsms_pkg::*;

	// Off phase always reports the drive forced to zero.
	a_off: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (motor_off == (phase == PH_OFF))) else $error("motor_off mismatch");
	// A target comes only from an up or down tick, which never ends in startup.
	a_tv: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && target_valid) |-> (phase != PH_STARTUP))
		else $error("target outside motion");
	// An accepted request holds off the next one: the input stalls in the cycle after it.
	a_one: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> in_stall) else $error("request overlap");
	// A stalled result holds.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |=> (out_valid && $stable(phase))) else $error("result dropped");
endmodule

bind timed_stroke_motion_sequencer_top tsms_checker u_chk (
	.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_stall(in_stall),
	.out_valid(out_valid), .out_stall(out_stall), .phase(phase),
	.control_mode(control_mode), .target_valid(target_valid), .motor_off(motor_off)
);
`default_nettype wire
